>>> sv/dmssh_pkg.sv
// Package for the Davies-Meyer Speck128/256 string hash.
// Holds the shared types, codes and cipher constants; depends on nothing.
`default_nettype none

package dmssh_pkg;

  // Cipher geometry.
  localparam int unsigned CIPHER_ROUNDS = 34;
  localparam int unsigned ROUND_W       = 6;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(CIPHER_ROUNDS - 1);

  // Message block layout.
  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned BIDX_W      = 5;
  localparam logic [BIDX_W-1:0] LAST_BIDX  = BIDX_W'(BLOCK_BYTES - 1);
  localparam logic [BIDX_W-1:0] LEN_OFFSET = BIDX_W'(28);
  localparam logic [7:0]        PAD_BYTE   = 8'h80;

  // Operation codes of an input transaction.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Configuration register map (64-bit registers at byte address 8*i).
  localparam int unsigned ADDR_W = 5;
  localparam logic [1:0] REG_SEED      = 2'd0;
  localparam logic [1:0] REG_INIT_LOW  = 2'd1;
  localparam logic [1:0] REG_INIT_HIGH = 2'd2;

  typedef logic [1:0][63:0] blk128_t;
  typedef logic [3:0][63:0] key256_t;

  // Configuration view seen by the sequencer.
  typedef struct packed {
    logic        wr;
    logic [63:0] start_low;
    logic [63:0] start_high;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FIN_C1,
    ST_FIN_C2,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> sv/dmssh_round.sv
// One Speck128/256 round with its key-schedule step, shared over all rounds.
// Depends on dmssh_pkg.
`default_nettype none

module dmssh_round
  import dmssh_pkg::*;
(
  input  blk128_t              x_i,
  input  key256_t              k_i,
  input  logic [ROUND_W-1:0]   rnd_i,
  output blk128_t              x_o,
  output key256_t              k_o
);

  logic [63:0] x1_new;
  logic [63:0] k3_new;

  // Data half: x1 = (ror8(x1) + x0) ^ k0, x0 = ror61(x0) ^ x1.
  assign x1_new = ({x_i[1][7:0], x_i[1][63:8]} + x_i[0]) ^ k_i[0];
  assign x_o[1] = x1_new;
  assign x_o[0] = {x_i[0][60:0], x_i[0][63:61]} ^ x1_new;

  // Key schedule: the same round keyed by the round counter, words rotate.
  assign k3_new = ({k_i[1][7:0], k_i[1][63:8]} + k_i[0]) ^ 64'(rnd_i);
  assign k_o[3] = k3_new;
  assign k_o[0] = {k_i[0][60:0], k_i[0][63:61]} ^ k3_new;
  assign k_o[1] = k_i[2];
  assign k_o[2] = k_i[3];

endmodule

`default_nettype wire

>>> sv/dmssh_cipher.sv
// Iterative Speck128/256 engine: one round a cycle through dmssh_round.
// Depends on dmssh_pkg and dmssh_round.
`default_nettype none

module dmssh_cipher
  import dmssh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  blk128_t pt_i,
  input  key256_t key_i,
  output logic    done_o,
  output blk128_t ct_o
);

  blk128_t            x_q, x_d, x_nx;
  key256_t            rk_q, rk_d, rk_nx;
  logic [ROUND_W-1:0] rnd_q, rnd_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  dmssh_round u_round (
    .x_i   (x_q),
    .k_i   (rk_q),
    .rnd_i (rnd_q),
    .x_o   (x_nx),
    .k_o   (rk_nx)
  );

  // Load on start, then step one round per cycle until the last round.
  always_comb begin
    x_d    = x_q;
    rk_d   = rk_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = pt_i;
      rk_d   = key_i;
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d   = x_nx;
      rk_d  = rk_nx;
      rnd_d = rnd_q + ROUND_W'(1);
      if (rnd_q == LAST_ROUND) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  // Cipher state and round keys.
  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    rk_q <= rk_d;
  end

  assign done_o = done_q;
  assign ct_o   = x_q;

endmodule

`default_nettype wire

>>> sv/dmssh_cfg.sv
// APB-style register file for seed and initial chain words.
// Depends on dmssh_pkg.
`default_nettype none

module dmssh_cfg
  import dmssh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [63:0] seed_q, seed_d;
  logic [63:0] init_low_q, init_low_d;
  logic [63:0] init_high_q, init_high_d;
  logic        wr;
  logic [1:0]  idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:3];
  assign pready = 1'b1;

  // Register write decode; addresses past the map are ignored.
  always_comb begin
    seed_d      = seed_q;
    init_low_d  = init_low_q;
    init_high_d = init_high_q;
    if (wr) begin
      unique case (idx)
        REG_SEED:      seed_d      = pwdata;
        REG_INIT_LOW:  init_low_d  = pwdata;
        REG_INIT_HIGH: init_high_d = pwdata;
        default: ;
      endcase
    end
  end

  // Read-back decode.
  always_comb begin
    unique case (idx)
      REG_SEED:      prdata = seed_q;
      REG_INIT_LOW:  prdata = init_low_q;
      REG_INIT_HIGH: prdata = init_high_q;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      init_low_q  <= '0;
      init_high_q <= '0;
    end else begin
      seed_q      <= seed_d;
      init_low_q  <= init_low_d;
      init_high_q <= init_high_d;
    end
  end

  // Starting chain words, already reflecting a write in this cycle.
  assign cfg_o.wr         = wr;
  assign cfg_o.start_low  = init_low_d ^ seed_d;
  assign cfg_o.start_high = init_high_d ^ seed_d;

endmodule

`default_nettype wire

>>> sv/davies_meyer_speck_string_hash.sv
// Davies-Meyer string hash over Speck128/256, one key byte per transaction.
// An append only stores the byte; every 32nd byte adds a compression
// (load, 34 rounds of the single round unit, chain update), ready being low.
// A finish compresses the padded block, and a second block when the padding spills,
// then moves the digest into the output register once the output is free.
// Reset clears the control registers and the chain to zero; no clearing pass.
`default_nettype none

module davies_meyer_speck_string_hash
  import dmssh_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [7:0]        key_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       digest_low_o,
  output logic [63:0]       digest_high_o
);

  localparam int unsigned CntW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [CntW-1:0] MaxBytes = CntW'(MAX_KEY_BYTES);

  state_e                       state_q, state_d;
  blk128_t                      chain_q, chain_d;
  logic [BLOCK_BYTES-1:0][7:0]  blk_q, blk_d;
  logic [BIDX_W-1:0]            bidx_q, bidx_d;
  logic [CntW-1:0]              bcnt_q, bcnt_d;
  logic                         start_q, start_d;
  logic                         out_valid_q, out_valid_d;
  logic [63:0]                  dig_lo_q, dig_lo_d;
  logic [63:0]                  dig_hi_q, dig_hi_d;
  cfg_t                         cfg;
  logic                         ct_done;
  blk128_t                      ct;
  logic                         in_fire;
  logic                         out_free;
  logic [31:0]                  bit_len;
  blk128_t                      start_chain;

  dmssh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmssh_cipher u_cipher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .pt_i    (chain_q),
    .key_i   (key256_t'(blk_q)),
    .done_o  (ct_done),
    .ct_o    (ct)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign bit_len     = 32'({bcnt_q, 3'b000});
  assign start_chain = {cfg.start_high, cfg.start_low};

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_FINISH) begin
            state_d = (bidx_q >= LEN_OFFSET) ? ST_FIN_C1 : ST_FIN_C2;
          end else if ((bcnt_q < MaxBytes) && (bidx_q == LAST_BIDX)) begin
            state_d = ST_ABSORB;
          end
        end
      end
      ST_ABSORB: begin
        if (ct_done) state_d = ST_IDLE;
      end
      ST_FIN_C1: begin
        if (ct_done) state_d = ST_FIN_C2;
      end
      ST_FIN_C2: begin
        if (ct_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates driven by the sequencer.
  always_comb begin
    chain_d     = chain_q;
    blk_d       = blk_q;
    bidx_d      = bidx_q;
    bcnt_d      = bcnt_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    dig_lo_d    = dig_lo_q;
    dig_hi_d    = dig_hi_q;

    // A register write outside a message reloads the chain at once.
    if (cfg.wr && (bcnt_q == '0)) begin
      chain_d = start_chain;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_APPEND) begin
            if (bcnt_q < MaxBytes) begin
              blk_d[bidx_q] = key_byte_i;
              bidx_d        = bidx_q + BIDX_W'(1);
              bcnt_d        = bcnt_q + CntW'(1);
              start_d       = (bidx_q == LAST_BIDX);
            end
          end else begin
            // Pad with the marker byte and zeros after it.
            for (int j = 0; j < BLOCK_BYTES; j++) begin
              if (BIDX_W'(j) == bidx_q) begin
                blk_d[j] = PAD_BYTE;
              end else if (BIDX_W'(j) > bidx_q) begin
                blk_d[j] = '0;
              end
            end
            // The length fits in this block only if the marker left room.
            if (bidx_q < LEN_OFFSET) begin
              blk_d[BLOCK_BYTES-1:BLOCK_BYTES-4] = bit_len;
            end
            start_d = 1'b1;
          end
        end
      end
      ST_ABSORB: begin
        if (ct_done) chain_d = chain_q ^ ct;
      end
      ST_FIN_C1: begin
        // Spill block: an all-zero block carrying only the length.
        if (ct_done) begin
          chain_d                            = chain_q ^ ct;
          blk_d                              = '0;
          blk_d[BLOCK_BYTES-1:BLOCK_BYTES-4] = bit_len;
          start_d                            = 1'b1;
        end
      end
      ST_FIN_C2: begin
        if (ct_done) chain_d = chain_q ^ ct;
      end
      ST_DONE: begin
        // Hand the digest over and start the next message.
        if (out_free) begin
          dig_lo_d    = chain_q[0];
          dig_hi_d    = chain_q[1];
          out_valid_d = 1'b1;
          chain_d     = start_chain;
          bidx_d      = '0;
          bcnt_d      = '0;
        end
      end
      default: ;
    endcase
  end

  // Control and chain state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= '0;
      bidx_q      <= '0;
      bcnt_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      bidx_q      <= bidx_d;
      bcnt_q      <= bcnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    dig_lo_q <= dig_lo_d;
    dig_hi_q <= dig_hi_d;
  end

  assign out_valid_o   = out_valid_q;
  assign digest_low_o  = dig_lo_q;
  assign digest_high_o = dig_hi_q;

endmodule

`default_nettype wire
